// ----- hw/rtl/lmbcm_pkg.sv -----
// Shared constants for the LED matrix bit-plane row scanner.
// Field widths, reset values and parameter defaults; no dependencies.
package lmbcm_pkg;

    localparam int COLUMNS           = 64;
    localparam int COL_W             = 6;
    localparam int COLOR_W           = 6;
    localparam int ROW_W             = 5;
    localparam int PLANE_W           = 3;
    localparam int HEIGHT_W          = 7;
    localparam int INDEX_W           = 15;
    localparam int TICK_W            = 7;
    // Wide enough for any scan address, including ones past the store.
    localparam int ADDR_W            = 16;

    localparam int DEF_BIT_PLANES    = 6;
    localparam int DEF_MAX_ROWS      = 64;

    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 7'd32;
    localparam logic [HEIGHT_W-1:0] HEIGHT_WIDE  = 7'd32;
    localparam logic [TICK_W-1:0]   TICK_LAST    = 7'd64;
    localparam logic [COL_W-1:0]    COL_LAST     = 6'(COLUMNS - 1);

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

endpackage

// ----- hw/rtl/led_matrix_bcm_row_scanner.sv -----
// Bit-plane (binary code modulation) row scanner for a dual-row RGB LED panel.
// Holds the frame store memory and the scan sequencer; uses lmbcm_pkg.
//
// Usage:
//   s_* channel: one beat per item. s_func = 0 writes s_write_bits into the
//   frame store at s_write_index (indexes past the store are dropped and give
//   no result). s_func = 1 is a refresh tick: the 64 words of the current row
//   and plane are read, one per cycle while the output buffer has room, and
//   sent as 64 m_* beats, the last one flagged by m_last. After the last beat is
//   taken the tick counter advances; the plane and row counters step on set tick counts.
//   cfg_* channel: writes panel_height (reset 32); always ready, to be used
//   only while the block is idle.
//   Timing: after a tick is accepted each word passes the read stage and the
//   output buffer before it leaves, and one beat follows every cycle while
//   m_ready stays high; the rate is set by the single read port of the frame
//   store. Items are taken one at a time:
//   s_ready stays low from a tick's acceptance until its last beat is taken.
//   Reset: the frame store is cleared by a pass over all 64*MAX_ROWS*BIT_PLANES
//   words (24576 with defaults), during which s_ready is low.
//   Stalls: a two-entry output buffer holds results; reads pause while it is
//   full and resume without loss when m_ready returns.
module led_matrix_bcm_row_scanner #(
    parameter int BIT_PLANES = lmbcm_pkg::DEF_BIT_PLANES,
    parameter int MAX_ROWS   = lmbcm_pkg::DEF_MAX_ROWS
) (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lmbcm_pkg::HEIGHT_W-1:0] cfg_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [lmbcm_pkg::INDEX_W-1:0]  s_write_index,
    input  logic [lmbcm_pkg::COLOR_W-1:0]  s_write_bits,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [lmbcm_pkg::COL_W-1:0]    m_column,
    output logic [lmbcm_pkg::COLOR_W-1:0]  m_color_bits,
    output logic [lmbcm_pkg::ROW_W-1:0]    m_row_address,
    output logic [lmbcm_pkg::PLANE_W-1:0]  m_plane,
    output logic                           m_last
);
    import lmbcm_pkg::*;

    localparam int DEPTH  = COLUMNS * MAX_ROWS * BIT_PLANES;
    localparam int MEM_AW = $clog2(DEPTH);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t                state_reg;
    logic [MEM_AW-1:0]     clr_addr_reg;
    logic [HEIGHT_W-1:0]   height_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [PLANE_W-1:0]    plane_reg;
    logic [TICK_W-1:0]     tick_reg;
    logic [ADDR_W-1:0]     base_reg;
    logic [COL_W-1:0]      col_reg;

    // Read stage: one read in flight at most.
    logic                  rd_vld_reg;
    logic                  rd_oob_reg;
    logic [COL_W-1:0]      rd_col_reg;
    logic [COLOR_W-1:0]    rd_data_reg;

    // Two-entry output buffer; entry 0 drives m_column, m_color_bits and m_last.
    logic [1:0]            count_reg;
    logic [COL_W-1:0]      e_col_reg   [2];
    logic [COLOR_W-1:0]    e_color_reg [2];

    logic [COLOR_W-1:0]    frame_mem [DEPTH];

    logic                  s_accept;
    logic                  pop;
    logic                  push;
    logic                  issue;
    logic [1:0]            occ;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  rd_oob;
    logic                  wr_en;
    logic [MEM_AW-1:0]     wr_addr;
    logic [COLOR_W-1:0]    wr_data;
    logic [COLOR_W-1:0]    push_color;
    logic [9:0]            plane_rows;
    logic [ADDR_W-1:0]     base_next;
    logic [TICK_W-1:0]     tick_next;
    logic                  plane_step;
    logic [PLANE_W:0]      plane_inc;
    logic [ROW_W-1:0]      row_inc;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;

    assign m_valid       = (count_reg != 2'd0);
    assign m_column      = e_col_reg[0];
    assign m_color_bits  = e_color_reg[0];
    assign m_last        = (e_col_reg[0] == COL_LAST);
    assign m_plane       = plane_reg;
    assign m_row_address = (height_reg > HEIGHT_WIDE) ? row_reg : {1'b0, row_reg[ROW_W-2:0]};

    assign pop   = m_valid && m_ready;
    assign push  = rd_vld_reg;
    assign occ   = count_reg + {1'b0, rd_vld_reg};
    // The buffer plus the read in flight never holds more than two beats.
    assign issue = (state_reg == ST_SCAN) && ((occ < 2'd2) || pop);

    assign rd_addr    = base_reg + ADDR_W'(col_reg);
    assign rd_oob     = (rd_addr >= ADDR_W'(DEPTH));
    assign push_color = rd_oob_reg ? '0 : rd_data_reg;

    assign plane_rows = {1'b0, plane_reg} * {3'b000, height_reg};
    assign base_next  = ADDR_W'({row_reg, 6'b000000}) + ADDR_W'({plane_rows, 6'b000000});

    always_comb begin
        tick_next  = (tick_reg == TICK_LAST) ? '0 : tick_reg + 7'd1;
        // Plane steps at tick counts 1, 2, 4, 8, 16 and 32.
        plane_step = (tick_next != '0) && !tick_next[TICK_W-1]
                     && ((tick_next & (tick_next - 7'd1)) == '0);
        plane_inc  = {1'b0, plane_reg} + 4'd1;
        row_inc    = row_reg + 5'd1;
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_addr_reg;
        wr_data = '0;
        if (state_reg == ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (s_accept && (s_func == FUNC_WRITE)
                     && ({1'b0, s_write_index} < ADDR_W'(DEPTH))) begin
            wr_en   = 1'b1;
            wr_addr = s_write_index[MEM_AW-1:0];
            wr_data = s_write_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            frame_mem[wr_addr] <= wr_data;
        end
        if (issue) begin
            rd_data_reg <= frame_mem[rd_addr[MEM_AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            height_reg   <= HEIGHT_RESET;
            row_reg      <= '0;
            plane_reg    <= '0;
            tick_reg     <= '0;
            col_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            count_reg    <= 2'd0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                height_reg <= cfg_data;
            end

            rd_vld_reg <= issue;
            if (issue) begin
                rd_oob_reg <= rd_oob;
                rd_col_reg <= col_reg;
                col_reg    <= col_reg + 6'd1;
            end

            if (pop) begin
                if (count_reg == 2'd2) begin
                    e_col_reg[0]   <= e_col_reg[1];
                    e_color_reg[0] <= e_color_reg[1];
                    if (push) begin
                        e_col_reg[1]   <= rd_col_reg;
                        e_color_reg[1] <= push_color;
                    end
                end else if (push) begin
                    e_col_reg[0]   <= rd_col_reg;
                    e_color_reg[0] <= push_color;
                end
                if (!push) begin
                    count_reg <= count_reg - 2'd1;
                end
            end else if (push) begin
                if (count_reg == 2'd0) begin
                    e_col_reg[0]   <= rd_col_reg;
                    e_color_reg[0] <= push_color;
                end else begin
                    e_col_reg[1]   <= rd_col_reg;
                    e_color_reg[1] <= push_color;
                end
                count_reg <= count_reg + 2'd1;
            end

            unique case (state_reg)
                ST_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == MEM_AW'(DEPTH - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_accept && (s_func == FUNC_TICK)) begin
                        base_reg  <= base_next;
                        col_reg   <= '0;
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (issue && (col_reg == COL_LAST)) begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    // Counters move only once the tick's final beat is taken.
                    if (pop && m_last) begin
                        tick_reg  <= tick_next;
                        state_reg <= ST_IDLE;
                        if (plane_step) begin
                            if (plane_inc >= (PLANE_W+1)'(BIT_PLANES)) begin
                                plane_reg <= '0;
                                if ({1'b0, row_inc} >= height_reg[HEIGHT_W-1:1]) begin
                                    row_reg <= '0;
                                end else begin
                                    row_reg <= row_inc;
                                end
                            end else begin
                                plane_reg <= plane_inc[PLANE_W-1:0];
                            end
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_buffer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (occ <= 2'd2) && (count_reg != 2'd3))
        else $error("output buffer overfilled");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!m_valid && !rd_vld_reg))
        else $error("input taken while results are still pending");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last) |=> s_ready)
        else $error("scanner did not return to idle after the last beat");

    a_no_read_while_clearing: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR) |-> (!issue && !m_valid))
        else $error("frame store read during the clearing pass");
`endif

endmodule
